>>> rtl/mmpp_pkg.sv
// package for the min/max peak pyramid
// types, constants and register indexes shared by the cells, the top level and the checker
`default_nettype none

package mmpp_pkg;

  localparam int LEVELS      = 16;
  localparam int SAMPLE_BITS = 24;
  localparam int LVL_W       = 4;
  localparam int CNT_W       = 16;
  localparam int LCNT_W      = 5;
  localparam int CFG_AW      = 8;
  localparam int CFG_DW      = 16;
  localparam int IN_TDATA_W  = ((SAMPLE_BITS + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((2 * SAMPLE_BITS + 7) / 8) * 8;

  typedef logic signed [SAMPLE_BITS-1:0] smp_t;

  localparam smp_t SMP_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam smp_t SMP_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  localparam logic [CNT_W-1:0] CNT_SAT     = {CNT_W{1'b1}};
  localparam logic [CNT_W-1:0] BUCKET_RST  = CNT_W'(480);
  localparam logic [LCNT_W-1:0] LCOUNT_RST = LCNT_W'(16);

  typedef enum logic [CFG_AW-1:0] {
    REG_BUCKET_LEN  = CFG_AW'(0),
    REG_LEVEL_COUNT = CFG_AW'(1)
  } reg_idx_e;

  // pair handed from one level cell to the next
  typedef struct packed {
    logic valid;
    smp_t mn;
    smp_t mx;
  } tok_t;

  // result offered by a level cell
  typedef struct packed {
    logic valid;
    logic last;
    smp_t mn;
    smp_t mx;
  } res_t;

endpackage

`default_nettype wire

>>> rtl/mmpp_cell.sv
// one level cell of the pyramid: holds the unpaired pair of its level
// and passes combined pairs to the next cell; uses mmpp_pkg
`default_nettype none

module mmpp_cell (
  input  wire               clk_i,
  input  wire               rst_ni,
  input  wire               adv_i,
  input  wire               is_top_i,
  input  wire               clr_i,
  input  mmpp_pkg::tok_t    push_i,
  output mmpp_pkg::tok_t    push_o,
  output mmpp_pkg::res_t    res_o
);
  import mmpp_pkg::*;

  logic tokv_q;
  smp_t tok_mn_q, tok_mx_q;
  logic hv_q;
  smp_t held_mn_q, held_mx_q;
  logic proc;
  smp_t cmn, cmx;

  assign proc = tokv_q & adv_i;
  assign cmn  = (held_mn_q < tok_mn_q) ? held_mn_q : tok_mn_q;
  assign cmx  = (held_mx_q > tok_mx_q) ? held_mx_q : tok_mx_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tokv_q <= 1'b0;
      hv_q   <= 1'b0;
    end else begin
      if (push_i.valid) begin
        tokv_q <= 1'b1;
      end else if (proc) begin
        tokv_q <= 1'b0;
      end
      if (clr_i) begin
        hv_q <= 1'b0;
      end else if (proc && !is_top_i) begin
        hv_q <= ~hv_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.valid) begin
      tok_mn_q <= push_i.mn;
      tok_mx_q <= push_i.mx;
    end
    if (proc && !is_top_i && !hv_q) begin
      held_mn_q <= tok_mn_q;
      held_mx_q <= tok_mx_q;
    end
  end

  always_comb begin
    push_o.valid = proc & ~is_top_i & hv_q;
    push_o.mn    = cmn;
    push_o.mx    = cmx;
    res_o.valid  = proc;
    res_o.last   = is_top_i | ~hv_q;
    res_o.mn     = tok_mn_q;
    res_o.mx     = tok_mx_q;
  end

endmodule

`default_nettype wire

>>> rtl/minmax_peak_pyramid.sv
// min/max peak pyramid: base bucket accumulator, chain of level cells, output register
// depends on mmpp_pkg and mmpp_cell
// a result goes through the token register of its level cell and the output register
// a pair steps one level cell per cycle, with one result each, unless the output stalls
// input waits until a cascade ends; a flush then also clears the held pairs of all cells
// reset clears the run, all held flags and the output; registers return to 480 and 16
`default_nettype none

module minmax_peak_pyramid (
  input  wire                                 clk_i,
  input  wire                                 rst_ni,
  input  wire                                 s_axis_tvalid,
  output logic                                s_axis_tready,
  input  wire  [mmpp_pkg::IN_TDATA_W-1:0]     s_axis_tdata,   // sample
  input  wire                                 s_axis_tuser,   // mode
  output logic                                m_axis_tvalid,
  input  wire                                 m_axis_tready,
  output logic [mmpp_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,   // pair min, pair max
  output logic [mmpp_pkg::LVL_W-1:0]          m_axis_tuser,   // level
  output logic                                m_axis_tlast,
  input  wire                                 cfg_valid_i,
  output logic                                cfg_ready_o,
  input  wire  [mmpp_pkg::CFG_AW-1:0]         cfg_addr_i,
  input  wire  [mmpp_pkg::CFG_DW-1:0]         cfg_data_i
);
  import mmpp_pkg::*;

  logic [CNT_W-1:0]  bucket_len_q;
  logic [LCNT_W-1:0] level_count_q;
  smp_t              run_mn_q, run_mn_d, run_mx_q, run_mx_d;
  logic [CNT_W-1:0]  run_cnt_q, run_cnt_d, cnt_inc;
  logic              flush_q, flush_d;
  logic              out_v_q;
  logic              out_last_q;
  logic [LVL_W-1:0]  out_lvl_q;
  smp_t              out_mn_q, out_mx_q;

  tok_t              push [LEVELS+1];
  res_t              res  [LEVELS];
  logic [LEVELS-1:0] tok_busy;
  logic [LEVELS-1:0] is_top;
  logic              adv, clr, in_xfer, smp;
  smp_t              s_in, new_mn, new_mx;
  int                eff;
  logic              r_any, r_last;
  logic [LVL_W-1:0]  r_lvl;
  smp_t              r_mn, r_mx;

  assign cfg_ready_o   = 1'b1;
  assign adv           = ~out_v_q | m_axis_tready;
  assign s_axis_tready = ~(|tok_busy) & ~flush_q;
  assign in_xfer       = s_axis_tvalid & s_axis_tready;
  assign clr           = flush_q & ~(|tok_busy);
  assign s_in          = s_axis_tdata[SAMPLE_BITS-1:0];
  assign smp           = in_xfer & ~s_axis_tuser;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bucket_len_q  <= BUCKET_RST;
      level_count_q <= LCOUNT_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_addr_i)
        REG_BUCKET_LEN:  bucket_len_q  <= cfg_data_i[CNT_W-1:0];
        REG_LEVEL_COUNT: level_count_q <= cfg_data_i[LCNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (level_count_q == '0) begin
      eff = 1;
    end else if (int'(level_count_q) > LEVELS) begin
      eff = LEVELS;
    end else begin
      eff = int'(level_count_q);
    end
  end

  assign new_mn  = (s_in < run_mn_q) ? s_in : run_mn_q;
  assign new_mx  = (s_in > run_mx_q) ? s_in : run_mx_q;
  assign cnt_inc = (run_cnt_q == CNT_SAT) ? run_cnt_q : run_cnt_q + CNT_W'(1);

  always_comb begin
    run_mn_d     = run_mn_q;
    run_mx_d     = run_mx_q;
    run_cnt_d    = run_cnt_q;
    flush_d      = flush_q & ~clr;
    push[0]      = '0;
    if (in_xfer && s_axis_tuser) begin
      push[0].valid = (run_cnt_q != '0);
      push[0].mn    = run_mn_q;
      push[0].mx    = run_mx_q;
      run_mn_d      = SMP_MAX;
      run_mx_d      = SMP_MIN;
      run_cnt_d     = '0;
      flush_d       = 1'b1;
    end else if (smp) begin
      if (cnt_inc >= bucket_len_q) begin
        push[0].valid = 1'b1;
        push[0].mn    = new_mn;
        push[0].mx    = new_mx;
        run_mn_d      = SMP_MAX;
        run_mx_d      = SMP_MIN;
        run_cnt_d     = '0;
      end else begin
        run_mn_d  = new_mn;
        run_mx_d  = new_mx;
        run_cnt_d = cnt_inc;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_mn_q  <= SMP_MAX;
      run_mx_q  <= SMP_MIN;
      run_cnt_q <= '0;
      flush_q   <= 1'b0;
    end else begin
      run_mn_q  <= run_mn_d;
      run_mx_q  <= run_mx_d;
      run_cnt_q <= run_cnt_d;
      flush_q   <= flush_d;
    end
  end

  // a pair is in flight from the base until the cell that ends its cascade
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_busy <= '0;
    end else begin
      for (int k = 0; k < LEVELS; k++) begin
        if (push[k].valid) begin
          tok_busy[k] <= 1'b1;
        end else if (res[k].valid) begin
          tok_busy[k] <= 1'b0;
        end
      end
    end
  end

  for (genvar k = 0; k < LEVELS; k++) begin : g_cell
    assign is_top[k] = ((k + 1) >= eff);
    mmpp_cell u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .adv_i    (adv),
      .is_top_i (is_top[k]),
      .clr_i    (clr),
      .push_i   (push[k]),
      .push_o   (push[k+1]),
      .res_o    (res[k])
    );
  end

  always_comb begin
    r_any  = 1'b0;
    r_last = 1'b0;
    r_lvl  = '0;
    r_mn   = '0;
    r_mx   = '0;
    for (int k = 0; k < LEVELS; k++) begin
      if (res[k].valid) begin
        r_any  = 1'b1;
        r_last = r_last | res[k].last;
        r_lvl  = r_lvl | LVL_W'(k);
        r_mn   = r_mn | res[k].mn;
        r_mx   = r_mx | res[k].mx;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (adv) begin
      out_v_q <= r_any;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && r_any) begin
      out_last_q <= r_last;
      out_lvl_q  <= r_lvl;
      out_mn_q   <= r_mn;
      out_mx_q   <= r_mx;
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tlast  = out_last_q;
  assign m_axis_tuser  = out_lvl_q;
  assign m_axis_tdata  = OUT_TDATA_W'({out_mx_q, out_mn_q});

  // the top cell never passes a pair on
  logic unused_top_push;
  assign unused_top_push = push[LEVELS].valid;

endmodule

`default_nettype wire

>>> rtl/mmpp_checker.sv
// port-level checker for minmax_peak_pyramid, attached by bind
// depends on mmpp_pkg
`default_nettype none

module mmpp_checker (
  input wire                              clk_i,
  input wire                              rst_ni,
  input wire                              s_axis_tvalid,
  input wire                              s_axis_tready,
  input wire                              s_axis_tuser,
  input wire                              m_axis_tvalid,
  input wire                              m_axis_tready,
  input wire [mmpp_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
  input wire [mmpp_pkg::LVL_W-1:0]        m_axis_tuser,
  input wire                              m_axis_tlast
);
  import mmpp_pkg::*;

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)
      && $stable(m_axis_tlast))
    else $error("result changed while stalled");

  // a cascade in progress blocks new input
  a_cascade_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tlast |-> !s_axis_tready)
    else $error("input accepted during cascade");

  // a flush transfer is followed by the clearing cycle
  a_flush_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && s_axis_tuser |=> !s_axis_tready)
    else $error("input accepted right after flush");

  // a non-final result is never the top level
  a_nonlast_level: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tlast |-> m_axis_tuser != LVL_W'(LEVELS - 1))
    else $error("top level result not marked last");

endmodule

bind minmax_peak_pyramid mmpp_checker u_mmpp_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire

>>> verif/mmpp_checker.sv
`timescale 1ns / 1ps
// checker for minmax_peak_pyramid: follows config, input and output transfers on the ports,
// predicts every bucket pair from its own copy of the pyramid state and compares in order
// depends on mmpp_pkg
module mmpp_scoreboard (
  input  wire                                 clk_i,
  input  wire                                 rst_ni,
  input  wire                                 s_axis_tvalid,
  input  wire                                 s_axis_tready,
  input  wire  [mmpp_pkg::IN_TDATA_W-1:0]     s_axis_tdata,   // sample
  input  wire                                 s_axis_tuser,   // mode
  input  wire                                 m_axis_tvalid,
  input  wire                                 m_axis_tready,
  input  wire  [mmpp_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,   // pair min, pair max
  input  wire  [mmpp_pkg::LVL_W-1:0]          m_axis_tuser,   // level
  input  wire                                 m_axis_tlast,
  input  wire                                 cfg_valid_i,
  input  wire                                 cfg_ready_o,
  input  wire  [mmpp_pkg::CFG_AW-1:0]         cfg_addr_i,
  input  wire  [mmpp_pkg::CFG_DW-1:0]         cfg_data_i,
  output int                                  fail_count_o,
  output int                                  pending_o
);
  import mmpp_pkg::*;

  typedef struct packed {
    logic [LVL_W-1:0] level;
    smp_t             mn;
    smp_t             mx;
    logic             last;
  } bucket_t;

  bucket_t           expected_buckets[$];
  logic [CNT_W-1:0]  bucket_len;
  logic [LCNT_W-1:0] level_count;
  smp_t              run_min;
  smp_t              run_max;
  logic [CNT_W-1:0]  run_count;
  smp_t              held_min [LEVELS-1];
  smp_t              held_max [LEVELS-1];
  logic [LEVELS-2:0] held_valid;
  int                fail_cnt = 0;

  task automatic flag_mismatch(input string msg);
    fail_cnt++;
    $display("%0t ns: %s", $time, msg);
  endtask

  task automatic clear_run();
    run_min   = SMP_MAX;
    run_max   = SMP_MIN;
    run_count = '0;
  endtask

  // emit the base bucket, then merge upward while the current level holds a partner
  task automatic close_base_bucket();
    int unsigned      eff;
    int unsigned      lvl;
    int               n;
    logic             done;
    smp_t             mn;
    smp_t             mx;
    logic [LVL_W-1:0] lv_a [LEVELS];
    smp_t             mn_a [LEVELS];
    smp_t             mx_a [LEVELS];
    bucket_t          b;
    eff = level_count;
    if (eff == 0) eff = 1;
    if (eff > LEVELS) eff = LEVELS;
    mn = run_min;
    mx = run_max;
    clear_run();
    lv_a[0] = '0;
    mn_a[0] = mn;
    mx_a[0] = mx;
    n = 1;
    lvl = 0;
    done = 1'b0;
    while (!done && lvl + 1 < eff) begin
      if (!held_valid[lvl]) begin
        held_min[lvl]   = mn;
        held_max[lvl]   = mx;
        held_valid[lvl] = 1'b1;
        done = 1'b1;
      end else begin
        if (held_min[lvl] < mn) mn = held_min[lvl];
        if (held_max[lvl] > mx) mx = held_max[lvl];
        held_valid[lvl] = 1'b0;
        lvl++;
        lv_a[n] = LVL_W'(lvl);
        mn_a[n] = mn;
        mx_a[n] = mx;
        n++;
      end
    end
    for (int i = 0; i < n; i++) begin
      b.level = lv_a[i];
      b.mn    = mn_a[i];
      b.mx    = mx_a[i];
      b.last  = (i == n - 1);
      expected_buckets.insert(expected_buckets.size(), b);
    end
  endtask

  task automatic advance_pyramid(input logic flush, input smp_t smp);
    if (flush) begin
      if (run_count != 0) close_base_bucket();
      clear_run();
      held_valid = '0;
    end else begin
      if (smp < run_min) run_min = smp;
      if (smp > run_max) run_max = smp;
      if (run_count != CNT_SAT) run_count++;
      if (run_count >= bucket_len) close_base_bucket();
    end
  endtask

  task automatic check_bucket();
    bucket_t want;
    if (expected_buckets.size() == 0) begin
      flag_mismatch($sformatf("result at level %0d with nothing expected", m_axis_tuser));
    end else begin
      want = expected_buckets.pop_front();
      if (m_axis_tuser !== want.level)
        flag_mismatch($sformatf("level %0d, want %0d", m_axis_tuser, want.level));
      if (m_axis_tdata[SAMPLE_BITS-1:0] !== want.mn)
        flag_mismatch($sformatf("level %0d min %0d, want %0d", want.level,
                                $signed(m_axis_tdata[SAMPLE_BITS-1:0]), want.mn));
      if (m_axis_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS] !== want.mx)
        flag_mismatch($sformatf("level %0d max %0d, want %0d", want.level,
                                $signed(m_axis_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS]), want.mx));
      if (m_axis_tlast !== want.last)
        flag_mismatch($sformatf("level %0d last %b, want %b", want.level, m_axis_tlast,
                                want.last));
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bucket_len  = BUCKET_RST;
      level_count = LCOUNT_RST;
      clear_run();
      held_valid = '0;
      expected_buckets.delete();
    end else begin
      if (m_axis_tvalid && m_axis_tready) check_bucket();
      if (s_axis_tvalid && s_axis_tready)
        advance_pyramid(s_axis_tuser, s_axis_tdata[SAMPLE_BITS-1:0]);
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_addr_i)
          REG_BUCKET_LEN:  bucket_len = cfg_data_i[CNT_W-1:0];
          REG_LEVEL_COUNT: level_count = cfg_data_i[LCNT_W-1:0];
          default: ;
        endcase
      end
    end
    pending_o    = expected_buckets.size();
    fail_count_o = fail_cnt;
  end

endmodule

>>> verif/tb.sv
`timescale 1ns / 1ps
// top of the minmax_peak_pyramid testbench: clock, reset, stimulus phases and verdict
// depends on mmpp_pkg, minmax_peak_pyramid and mmpp_scoreboard
module tb;
  import mmpp_pkg::*;

  localparam int SETTLE_CYCLES = LEVELS + 8;

  logic                   clk_i         = 1'b0;
  logic                   rst_ni        = 1'b0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
  logic                   s_axis_tuser  = 1'b0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic [LVL_W-1:0]       m_axis_tuser;
  logic                   m_axis_tlast;
  logic                   cfg_valid_i   = 1'b0;
  logic                   cfg_ready_o;
  logic [CFG_AW-1:0]      cfg_addr_i    = '0;
  logic [CFG_DW-1:0]      cfg_data_i    = '0;
  int                     fail_count;
  int                     pending;
  int                     idle_pct      = 0;
  int                     stall_pct     = 0;

  minmax_peak_pyramid dut (.*);

  mmpp_scoreboard chk (
    .clk_i,
    .rst_ni,
    .s_axis_tvalid,
    .s_axis_tready,
    .s_axis_tdata,
    .s_axis_tuser,
    .m_axis_tvalid,
    .m_axis_tready,
    .m_axis_tdata,
    .m_axis_tuser,
    .m_axis_tlast,
    .cfg_valid_i,
    .cfg_ready_o,
    .cfg_addr_i,
    .cfg_data_i,
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  always @(negedge clk_i) begin
    m_axis_tready <= ($urandom_range(0, 99) >= stall_pct);
  end

  function automatic smp_t rand_sample();
    smp_t v;
    case ($urandom_range(0, 9))
      0:       v = SMP_MAX;
      1:       v = SMP_MIN;
      2:       v = smp_t'($urandom_range(0, 15)) - smp_t'(8);
      default: v = smp_t'($urandom);
    endcase
    return v;
  endfunction

  // starts and ends at a falling edge; valid stays high for a following transfer
  task automatic send_item(input logic flush, input smp_t smp);
    while ($urandom_range(0, 99) < idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= flush;
    s_axis_tdata  <= IN_TDATA_W'(unsigned'(smp));
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic random_run(input int n, input int flush_pct);
    for (int i = 0; i < n; i++) begin
      send_item($urandom_range(0, 99) < flush_pct, rand_sample());
    end
  endtask

  // items that close no bucket may still be in flight once nothing is expected
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic configure(input logic [CFG_DW-1:0] blen, input logic [CFG_DW-1:0] lcnt);
    drain();
    cfg_valid_i <= 1'b1;
    cfg_addr_i  <= REG_BUCKET_LEN;
    cfg_data_i  <= blen;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    @(negedge clk_i);
    cfg_addr_i  <= REG_LEVEL_COUNT;
    cfg_data_i  <= lcnt;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  initial begin
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // reset registers: flush of a partial bucket, then a flush with nothing open
    send_item(1'b0, SMP_MAX);
    send_item(1'b0, SMP_MIN);
    send_item(1'b0, '0);
    send_item(1'b1, smp_t'(24'h5A5A5A));
    send_item(1'b1, SMP_MAX);

    // zero bucket length and zero level count
    configure(16'd0, 16'd0);
    send_item(1'b0, smp_t'(-1));
    send_item(1'b0, smp_t'(1));

    // one sample per bucket, cascade through the low levels
    configure(16'd1, 16'd16);
    send_item(1'b0, smp_t'(24'h7FFFFF));
    send_item(1'b0, smp_t'(24'h800000));
    send_item(1'b0, smp_t'(24'h555555));
    send_item(1'b0, smp_t'(24'hAAAAAA));
    send_item(1'b0, smp_t'(24'h000000));
    send_item(1'b0, smp_t'(24'hFFFFFF));
    send_item(1'b0, smp_t'(24'h000001));
    send_item(1'b0, smp_t'(24'h7FFFFE));
    send_item(1'b1, '0);

    // bucket length lowered with a bucket open
    configure(16'd4, 16'd2);
    send_item(1'b0, smp_t'(24'h123456));
    send_item(1'b0, smp_t'(24'hFEDCBA));
    send_item(1'b0, smp_t'(24'h00FF00));
    configure(16'd2, 16'd2);
    send_item(1'b0, smp_t'(24'h400000));
    send_item(1'b1, '0);

    // level count above the limit, then lowered and raised again without a flush
    idle_pct  = 0;
    stall_pct = 0;
    configure(16'd1, 16'd31);
    random_run(130, 0);
    idle_pct  = 58;
    stall_pct = 0;
    configure(16'd0, 16'd4);
    random_run(60, 0);
    idle_pct  = 25;
    stall_pct = 25;
    configure(16'd1, 16'd16);
    random_run(130, 0);
    send_item(1'b1, rand_sample());

    idle_pct  = 0;
    stall_pct = 58;
    configure(16'($urandom_range(2, 7)), 16'($urandom_range(1, 8)));
    random_run(70, 5);

    idle_pct  = 58;
    stall_pct = 58;
    configure(16'hFFFF, 16'd16);
    random_run(10, 0);
    send_item(1'b1, rand_sample());

    idle_pct  = 25;
    stall_pct = 25;
    configure(16'd3, 16'd0);
    random_run(35, 8);

    drain();
    if (fail_count == 0 && pending == 0) begin
      $display("minmax_peak_pyramid: match");
    end else begin
      $display("minmax_peak_pyramid: mismatch");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("minmax_peak_pyramid: mismatch");
    $finish;
  end

endmodule
